[rtl/text_console_writer_defines.svh]
// assertion macros shared by the console writer checker
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tcw_pkg.sv]
// shared types and constants for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int OP_W    = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int INDEX_W = 11;
	localparam int POS_W   = 11;
	localparam int CELL_W  = 16;

	// item operation codes
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h02;
	localparam logic [CELL_W-1:0]  RESET_CELL  = 16'h0220;

	// input word
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [CHAR_W-1:0]  char_code;
		logic [INDEX_W-1:0] cell_index;
	} tcw_in_t;

	// output word
	typedef struct packed {
		logic [POS_W-1:0]  cursor_position;
		logic [CELL_W-1:0] read_data;
		logic              scrolled;
	} tcw_out_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic sweep_clr;
		logic sweep_move;
		logic sweep_inc;
		logic fill_we;
		logic zero_we;
		logic copy_rd;
		logic rd_load;
	} tcw_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_full;
		logic wrap_scroll;
		logic sweep_end;
		logic move_end;
	} tcw_status_t;

endpackage

[rtl/text_console_writer.sv]
// Text console writer: put, clear and read on a COLUMNS x ROWS cell store.
// Put, clear and unused-op results show in the cycle after acceptance; a read also passes ST_RD.
// Throughput: one non-scrolling put per cycle unless the output stalls; a read, a clear or
// a scrolling put holds input until its pass ends; a scroll moves rows via the single write port.
// Reset (async, active low) homes the cursor, sets color 2 and then blanks every cell
// to 0x0220 in a pass during which no item is taken.
`timescale 1ns / 1ps

module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  tcw_pkg::tcw_in_t             in_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output tcw_pkg::tcw_out_t            out_word,
	input  logic                         cfg_we,
	input  logic [tcw_pkg::COLOR_W-1:0]  cfg_data
);

	tcw_pkg::tcw_cmd_t    cmd;
	tcw_pkg::tcw_status_t status;

	// sequencer
	tcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.op      (in_word.op),
		.status  (status),
		.in_stall(in_stall),
		.cmd     (cmd)
	);

	// cursor, store and output stage
	tcw_dpath #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.out_stall(out_stall),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_valid(out_valid),
		.out_word (out_word)
	);

endmodule

[rtl/tcw_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/tcw_ctrl.sv]
// sequencing state machine for the text console writer
`timescale 1ns / 1ps

module tcw_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [tcw_pkg::OP_W-1:0]  op,
	input  tcw_pkg::tcw_status_t      status,
	output logic                      in_stall,
	output tcw_pkg::tcw_cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_FILL  = 3'd2;
	localparam logic [2:0] ST_SCOPY = 3'd3;
	localparam logic [2:0] ST_SLAST = 3'd4;
	localparam logic [2:0] ST_SZERO = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       idle;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		idle     = (state_q == ST_IDLE);
		in_stall = !idle || status.out_full;
		cmd.accept = idle && in_valid && !status.out_full;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					unique case (op)
						tcw_pkg::OP_PUT: begin
							if (status.wrap_scroll) begin
								state_d       = ST_SCOPY;
								cmd.sweep_clr = 1'b1;
							end
						end
						tcw_pkg::OP_CLEAR: begin
							state_d       = ST_FILL;
							cmd.sweep_clr = 1'b1;
						end
						tcw_pkg::OP_READ: begin
							state_d = ST_RD;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RD: begin
				cmd.rd_load = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_FILL: begin
				cmd.fill_we   = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (status.sweep_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCOPY: begin
				cmd.copy_rd   = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (status.move_end) begin
					state_d = ST_SLAST;
				end
			end
			ST_SLAST: begin
				cmd.sweep_move = 1'b1;
				state_d        = ST_SZERO;
			end
			ST_SZERO: begin
				cmd.zero_we   = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (status.sweep_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register, reset starts the blanking pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/tcw_dpath.sv]
// cursor, cell store and output register of the text console writer
`timescale 1ns / 1ps

module tcw_dpath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcw_pkg::tcw_in_t              in_word,
	input  logic                          out_stall,
	input  logic                          cfg_we,
	input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
	input  tcw_pkg::tcw_cmd_t             cmd,
	output tcw_pkg::tcw_status_t          status,
	output logic                          out_valid,
	output tcw_pkg::tcw_out_t             out_word
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int MOVE  = COLUMNS * (ROWS - 1);
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int PW    = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;

	logic [CW-1:0]                  col_q;
	logic [RW-1:0]                  row_q;
	logic [AW-1:0]                  pos_q;
	logic [tcw_pkg::COLOR_W-1:0]    text_color_q;
	logic [tcw_pkg::CELL_W-1:0]     fill_word_q;
	logic [AW-1:0]                  sweep_q;
	logic                           copy_we_s1;
	logic [AW-1:0]                  copy_addr_s1;
	logic                           in_range_q;
	logic                           out_valid_q;
	tcw_pkg::tcw_out_t              out_word_q;

	logic                           col_last;
	logic                           row_last;
	logic                           is_put;
	logic                           is_clear;
	logic                           is_read;
	logic [PW-1:0]                  idx_ext;
	logic                           in_range;
	logic [AW:0]                    src_sum;
	logic [AW-1:0]                  pos_next;
	logic [PW-1:0]                  pos_next_ext;
	logic [PW-1:0]                  pos_cur_ext;
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [tcw_pkg::CELL_W-1:0]     ram_wdata;
	logic                           ram_re;
	logic [AW-1:0]                  ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]     ram_rdata;
	logic                           out_load;
	tcw_pkg::tcw_out_t              out_next;

	assign col_last = (col_q == CW'(COLUMNS - 1));
	assign row_last = (row_q == RW'(ROWS - 1));
	assign is_put   = cmd.accept && (in_word.op == tcw_pkg::OP_PUT);
	assign is_clear = cmd.accept && (in_word.op == tcw_pkg::OP_CLEAR);
	assign is_read  = cmd.accept && (in_word.op == tcw_pkg::OP_READ);

	// read index range check
	assign idx_ext  = PW'(in_word.cell_index);
	assign in_range = (idx_ext < PW'(CELLS));

	// scroll source is one row below the sweep
	assign src_sum = {1'b0, sweep_q} + (AW + 1)'(COLUMNS);

	// cursor position after a put
	always_comb begin
		if (col_last && row_last) begin
			pos_next = AW'(MOVE);
		end else begin
			pos_next = pos_q + AW'(1);
		end
	end

	assign pos_next_ext = PW'(pos_next);
	assign pos_cur_ext  = PW'(pos_q);

	assign status.out_full    = out_valid_q && out_stall;
	assign status.wrap_scroll = col_last && row_last;
	assign status.sweep_end   = (sweep_q == AW'(CELLS - 1));
	assign status.move_end    = (sweep_q == AW'(MOVE - 1));

	// ram write port select
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = {text_color_q, in_word.char_code};
		priority if (is_put) begin
			ram_we = 1'b1;
		end else if (copy_we_s1) begin
			ram_we    = 1'b1;
			ram_waddr = copy_addr_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.fill_we) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = fill_word_q;
		end else if (cmd.zero_we) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = '0;
		end
	end

	// ram read port select
	assign ram_re    = (is_read && in_range) || cmd.copy_rd;
	assign ram_raddr = cmd.copy_rd ? src_sum[AW-1:0] : idx_ext[AW-1:0];

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// output word select
	always_comb begin
		out_load = 1'b0;
		out_next = '0;
		if (cmd.rd_load) begin
			out_load                 = 1'b1;
			out_next.cursor_position = pos_cur_ext[tcw_pkg::POS_W-1:0];
			out_next.read_data       = in_range_q ? ram_rdata : '0;
		end else if (cmd.accept) begin
			unique case (in_word.op)
				tcw_pkg::OP_PUT: begin
					out_load                 = 1'b1;
					out_next.cursor_position = pos_next_ext[tcw_pkg::POS_W-1:0];
					out_next.scrolled        = col_last && row_last;
				end
				tcw_pkg::OP_CLEAR: begin
					out_load = 1'b1;
				end
				tcw_pkg::OP_READ: begin
					out_load = 1'b0;
				end
				default: begin
					out_load                 = 1'b1;
					out_next.cursor_position = pos_cur_ext[tcw_pkg::POS_W-1:0];
				end
			endcase
		end
	end

	// cursor, color and sweep control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			pos_q        <= '0;
			text_color_q <= tcw_pkg::RESET_COLOR;
			fill_word_q  <= tcw_pkg::RESET_CELL;
			sweep_q      <= '0;
			copy_we_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				text_color_q <= cfg_data;
			end
			if (is_put) begin
				pos_q <= pos_next;
				if (col_last) begin
					col_q <= '0;
					if (!row_last) begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (is_clear) begin
				col_q       <= '0;
				row_q       <= '0;
				pos_q       <= '0;
				fill_word_q <= {text_color_q, tcw_pkg::BLANK_CHAR};
			end
			priority if (cmd.sweep_clr) begin
				sweep_q <= '0;
			end else if (cmd.sweep_move) begin
				sweep_q <= AW'(MOVE);
			end else if (cmd.sweep_inc) begin
				sweep_q <= sweep_q + AW'(1);
			end
			copy_we_s1 <= cmd.copy_rd;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		copy_addr_s1 <= sweep_q;
		if (is_read) begin
			in_range_q <= in_range;
		end
		if (out_load) begin
			out_word_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

[rtl/tcw_checker.sv]
// port-level checks for the text console writer and their bind
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input tcw_pkg::tcw_in_t             in_word,
	input logic                         out_valid,
	input logic                         out_stall,
	input tcw_pkg::tcw_out_t            out_word
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam logic [tcw_pkg::POS_W-1:0] POS_MAX  = tcw_pkg::POS_W'(CELLS - 1);
	localparam logic [tcw_pkg::POS_W-1:0] LAST_ROW = tcw_pkg::POS_W'(COLUMNS * (ROWS - 1));

	// a stalled result word stays put
	`TCW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "result word changed while stalled")

	// the cursor never leaves the screen
	`TCW_ASSERT_NOW(a_pos_range, out_valid && (CELLS <= 2048), out_word.cursor_position <= POS_MAX, "cursor position beyond the screen")

	// a scroll leaves the cursor at the start of the last row
	`TCW_ASSERT_NOW(a_scroll_pos, out_valid && out_word.scrolled, out_word.cursor_position == LAST_ROW, "scroll left the cursor off the last row start")

	// input is stalled just after reset, as the blanking pass begins
	`TCW_ASSERT_NOW(a_reset_busy, !$past(arst_n), in_stall, "input taken during the reset blanking pass")

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (.*);

[sim/tb_top.sv]
// self-checking testbench for the text console writer: directed, random and scroll traffic
`timescale 1ns / 1ps

module tb_top;

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int CELL_TOTAL   = COLUMNS * ROWS;
	localparam int SWEEP_CYCLES = CELL_TOTAL + 1;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int REPORT_MAX   = 10;
	localparam logic [tcw_pkg::OP_W-1:0] OP_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	tcw_pkg::tcw_in_t in_word;
	logic out_valid;
	logic out_stall;
	tcw_pkg::tcw_out_t out_word;
	logic cfg_we;
	logic [tcw_pkg::COLOR_W-1:0] cfg_data;

	// console shadow: cell store, cursor and attribute byte
	logic [tcw_pkg::CELL_W-1:0] screen [0:CELL_TOTAL-1];
	logic [6:0] cur_col;
	logic [4:0] cur_row;
	logic [tcw_pkg::COLOR_W-1:0] cur_color;

	tcw_pkg::tcw_out_t screen_replies [$];
	tcw_pkg::tcw_out_t reply_want;

	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int rx_hold = 0;
	int rx_len;
	int cycle_count = 0;
	int mismatch_count = 0;
	int results_checked = 0;
	int words_sent = 0;
	int put_total = 0;
	int read_total = 0;
	int clear_total = 0;
	int scroll_total = 0;
	int color_writes = 0;

	text_console_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, screen_replies.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// linear cursor address in the shadow
	function automatic int cursor_linear();
		return int'(cur_row) * COLUMNS + int'(cur_col);
	endfunction

	// shadow state after reset
	function automatic void home_console();
		int i;
		for (i = 0; i < CELL_TOTAL; i++)
			screen[i] = tcw_pkg::RESET_CELL;
		cur_col = '0;
		cur_row = '0;
		cur_color = tcw_pkg::RESET_COLOR;
	endfunction

	// apply one word to the shadow and return the reply it should produce
	function automatic tcw_pkg::tcw_out_t apply_console_op(tcw_pkg::tcw_in_t w);
		tcw_pkg::tcw_out_t reply;
		int base;
		int i;
		reply = '0;
		case (w.op)
			tcw_pkg::OP_PUT: begin
				put_total++;
				base = cursor_linear();
				if (base < CELL_TOTAL)
					screen[base] = {cur_color, w.char_code};
				cur_col = cur_col + 1'b1;
				if (cur_col >= COLUMNS) begin
					cur_col = '0;
					cur_row = cur_row + 1'b1;
					// past the last row: move every row up, zero the bottom one
					if (cur_row >= ROWS) begin
						for (i = 0; i < CELL_TOTAL - COLUMNS; i++)
							screen[i] = screen[i + COLUMNS];
						for (i = CELL_TOTAL - COLUMNS; i < CELL_TOTAL; i++)
							screen[i] = '0;
						cur_row = 5'(ROWS - 1);
						reply.scrolled = 1'b1;
						scroll_total++;
					end
				end
			end
			tcw_pkg::OP_CLEAR: begin
				clear_total++;
				for (i = 0; i < CELL_TOTAL; i++)
					screen[i] = {cur_color, tcw_pkg::BLANK_CHAR};
				cur_col = '0;
				cur_row = '0;
			end
			tcw_pkg::OP_READ: begin
				read_total++;
				if (int'(w.cell_index) < CELL_TOTAL)
					reply.read_data = screen[w.cell_index];
			end
			default: begin
			end
		endcase
		reply.cursor_position = tcw_pkg::POS_W'(cursor_linear());
		return reply;
	endfunction

	function automatic tcw_pkg::tcw_in_t make_word(logic [tcw_pkg::OP_W-1:0] op, int ch,
		int idx);
		tcw_pkg::tcw_in_t w;
		w.op = op;
		w.char_code = tcw_pkg::CHAR_W'(ch);
		w.cell_index = tcw_pkg::INDEX_W'(idx);
		return w;
	endfunction

	// random word by percentage of puts, reads and clears; the rest is the unused code
	function automatic tcw_pkg::tcw_in_t random_word(int put_pct, int read_pct, int clear_pct);
		tcw_pkg::tcw_in_t w;
		int roll;
		int pick;
		int pos;
		roll = $urandom_range(99);
		w.char_code = tcw_pkg::CHAR_W'($urandom_range(255));
		w.cell_index = tcw_pkg::INDEX_W'($urandom_range(2047));
		if (roll < put_pct) begin
			w.op = tcw_pkg::OP_PUT;
		end else if (roll < put_pct + read_pct) begin
			w.op = tcw_pkg::OP_READ;
			pick = $urandom_range(99);
			// bias reads toward cells just written, some past the store
			if (pick < 40) begin
				pos = cursor_linear() - int'($urandom_range(8));
				w.cell_index = tcw_pkg::INDEX_W'((pos < 0) ? 0 : pos);
			end else if (pick < 88) begin
				w.cell_index = tcw_pkg::INDEX_W'($urandom_range(CELL_TOTAL - 1));
			end else begin
				w.cell_index = tcw_pkg::INDEX_W'($urandom_range(2047, CELL_TOTAL));
			end
		end else if (roll < put_pct + read_pct + clear_pct) begin
			w.op = tcw_pkg::OP_CLEAR;
		end else begin
			w.op = OP_NONE;
		end
		return w;
	endfunction

	// idle length: mostly short, a few long
	function automatic int pick_gap(bit quiet);
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// send one word, then record its expected reply
	task automatic send_word(tcw_pkg::tcw_in_t w);
		int gap;
		gap = pick_gap(tx_quiet);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		screen_replies.push_back(apply_console_op(w));
		words_sent++;
	endtask

	task automatic idle_sender();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		idle_sender();
		while (screen_replies.size() != 0)
			@(posedge clk);
	endtask

	// color write once idle; a clear or scroll sweep may still run after its reply
	task automatic set_text_color(logic [tcw_pkg::COLOR_W-1:0] color);
		wait_drained();
		repeat (SWEEP_CYCLES + 16) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= color;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_color = color;
		color_writes++;
	endtask

	// receiver stall: random, or a long hold when one is requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_len = rx_hold;
				rx_hold = 0;
			end else begin
				rx_len = pick_gap(rx_quiet);
			end
			if (rx_len > 0) begin
				out_stall <= 1'b1;
				repeat (rx_len) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// compare each accepted reply with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (screen_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected word at %0t: pos %0d data %h scrolled %b",
						$time, out_word.cursor_position, out_word.read_data,
						out_word.scrolled);
			end else begin
				reply_want = screen_replies.pop_front();
				results_checked++;
				if (out_word.cursor_position !== reply_want.cursor_position ||
					out_word.read_data !== reply_want.read_data ||
					out_word.scrolled !== reply_want.scrolled) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("mismatch at %0t: exp pos %0d data %h scr %b, got pos %0d data %h scr %b",
							$time, reply_want.cursor_position, reply_want.read_data,
							reply_want.scrolled, out_word.cursor_position,
							out_word.read_data, out_word.scrolled);
				end
			end
		end
	end

	// blank store at reset color, unused code, character extremes
	task automatic test_reset_contents();
		send_word(make_word(tcw_pkg::OP_READ, 0, 0));
		send_word(make_word(tcw_pkg::OP_READ, 255, CELL_TOTAL - 1));
		send_word(make_word(tcw_pkg::OP_READ, 0, CELL_TOTAL));
		send_word(make_word(tcw_pkg::OP_READ, 255, 2047));
		send_word(make_word(OP_NONE, 255, 2047));
		send_word(make_word(tcw_pkg::OP_PUT, 0, 0));
		send_word(make_word(tcw_pkg::OP_PUT, 255, 2047));
		send_word(make_word(tcw_pkg::OP_READ, 0, 0));
		send_word(make_word(tcw_pkg::OP_READ, 0, 1));
	endtask

	// attribute extremes on puts and on clear
	task automatic test_color_register();
		set_text_color(8'h00);
		send_word(make_word(tcw_pkg::OP_PUT, 8'h5A, 0));
		send_word(make_word(tcw_pkg::OP_READ, 0, 2));
		set_text_color(8'hFF);
		send_word(make_word(tcw_pkg::OP_CLEAR, 0, 0));
		send_word(make_word(tcw_pkg::OP_READ, 0, 0));
		send_word(make_word(tcw_pkg::OP_READ, 0, CELL_TOTAL - 1));
		send_word(make_word(OP_NONE, 0, 0));
		send_word(make_word(tcw_pkg::OP_PUT, 8'h41, 0));
		send_word(make_word(tcw_pkg::OP_READ, 0, 0));
	endtask

	// mixed operations under several colors, with quiet stretches and a pause
	task automatic test_mixed_traffic();
		logic [tcw_pkg::COLOR_W-1:0] colors [4];
		int p;
		int k;
		colors[0] = 8'h00;
		colors[1] = 8'hFF;
		colors[2] = tcw_pkg::COLOR_W'($urandom_range(255));
		colors[3] = 8'h1E;
		for (p = 0; p < 4; p++) begin
			set_text_color(colors[p]);
			for (k = 0; k < 60; k++) begin
				if (k % 30 == 0) begin
					tx_quiet = ($urandom_range(3) == 0);
					rx_quiet = ($urandom_range(3) == 0);
				end
				if (k == 45)
					wait_drained();
				send_word(random_word(62, 28, 4));
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// long receiver hold while words keep coming, then drain
	task automatic test_backpressure();
		int k;
		wait_drained();
		rx_hold = 400;
		tx_quiet = 1'b1;
		for (k = 0; k < 40; k++)
			send_word(random_word(70, 25, 0));
		tx_quiet = 1'b0;
		wait_drained();
	endtask

	// keep writing from the current cursor until the screen has scrolled twice
	task automatic test_scroll();
		int target;
		int k;
		set_text_color(tcw_pkg::COLOR_W'($urandom_range(255)));
		target = scroll_total + 2;
		k = 0;
		while (scroll_total < target) begin
			if (k % 200 == 0) begin
				tx_quiet = ($urandom_range(4) == 0);
				rx_quiet = ($urandom_range(4) == 0);
			end
			send_word(random_word(97, 3, 0));
			k++;
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		// check the shifted rows and the zeroed bottom line
		for (k = 0; k < 30; k++)
			send_word(random_word(0, 100, 0));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		home_console();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_contents();
		test_color_register();
		test_mixed_traffic();
		test_backpressure();
		test_scroll();

		wait_drained();
		repeat (64) @(posedge clk);

		$display("sent %0d words: %0d puts, %0d reads, %0d clears, %0d scrolls, %0d colors",
			words_sent, put_total, read_total, clear_total, scroll_total, color_writes);
		$display("checked %0d replies, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0 && screen_replies.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[text_console_writer.f]
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/tcw_dpath.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
sim/tb_top.sv
